FILE: sv/microprogram_sequencer_assert.svh
// Assertion macros for the microprogram sequencer.
`ifndef MICROPROGRAM_SEQUENCER_ASSERT_SVH
`define MICROPROGRAM_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSQ_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("msq assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MSQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("msq assertion failed");

`endif

FILE: sv/msq_pkg.sv
// Types and constants shared by the microprogram sequencer files.
`default_nettype none
package msq_pkg;

  localparam int unsigned DATA_W = 12;
  localparam int unsigned OP_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_JZ   = 4'd0,
    OP_CJS  = 4'd1,
    OP_JMAP = 4'd2,
    OP_CJP  = 4'd3,
    OP_PUSH = 4'd4,
    OP_JSRP = 4'd5,
    OP_CJV  = 4'd6,
    OP_JRP  = 4'd7,
    OP_RFCT = 4'd8,
    OP_RPCT = 4'd9,
    OP_CRTN = 4'd10,
    OP_CJPP = 4'd11,
    OP_LDCT = 4'd12,
    OP_LOOP = 4'd13,
    OP_CONT = 4'd14,
    OP_TWB  = 4'd15
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   instruction;
    logic              cond_fail;
    logic [DATA_W-1:0] branch_data;
    logic              load_counter_n;
  } msq_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] next_address;
    logic              stack_full_n;
  } msq_out_t;

  // Stack operation for one microcycle; at most one of push and pop is set.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } msq_stk_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/msq_stack.sv
// Return stack with level pointer: overwrite on full push, no-op on empty pop.
`default_nettype none
module msq_stack import msq_pkg::*; #(
  parameter int unsigned AW    = 12,
  parameter int unsigned DEPTH = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire msq_stk_ctrl_t ctrl_i,
  input  wire logic [AW-1:0] push_data_i,
  output logic [AW-1:0]      top_o,
  output logic               full_next_o
);

  localparam int unsigned LvlW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LvlW-1:0] LvlFull = LvlW'(DEPTH);
  localparam logic [LvlW-1:0] LvlOne  = LvlW'(1);

  logic [AW-1:0]   mem_q [DEPTH];
  logic [LvlW-1:0] level_q, level_d;
  logic [IdxW-1:0] wr_idx, rd_idx;
  logic            full;

  assign full   = (level_q >= LvlFull);
  assign wr_idx = full ? IdxW'(LvlFull - LvlOne) : IdxW'(level_q);
  // empty stack reads entry 0
  assign rd_idx = (level_q == '0) ? '0 : IdxW'(level_q - LvlOne);
  assign top_o  = mem_q[rd_idx];

  always_comb begin
    level_d = level_q;
    if (ctrl_i.clear) begin
      level_d = '0;
    end else if (ctrl_i.push) begin
      level_d = full ? LvlFull : level_q + LvlOne;
    end else if (ctrl_i.pop && (level_q != '0)) begin
      level_d = level_q - LvlOne;
    end
  end

  assign full_next_o = (level_d >= LvlFull);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      for (int i = 0; i < int'(DEPTH); i++) begin
        mem_q[i] <= '0;
      end
    end else begin
      level_q <= level_d;
      if (ctrl_i.push) begin
        mem_q[wr_idx] <= push_data_i;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/microprogram_sequencer.sv
// One request per cycle is sustained while out_ready_i is high.
// Stage 1 registers the request; stage 2 decodes it against PC, loop counter and stack,
// updates that state and loads the result register in the same cycle.
// A stalled result with a request waiting behind it holds in_ready_o low.
// Reset (async, active low) zeroes PC, loop counter, stack level and all stack entries,
// and empties both pipeline registers.
`default_nettype none
`include "microprogram_sequencer_assert.svh"
module microprogram_sequencer import msq_pkg::*; #(
  parameter int unsigned ADDR_WIDTH  = 12,
  parameter int unsigned STACK_DEPTH = 9
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire msq_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output msq_out_t      out_data_o
);

  localparam int unsigned AW = ADDR_WIDTH;
  localparam logic [AW-1:0] AddrOne = AW'(1);

  msq_in_t       in_q;
  logic          in_valid_q;
  msq_out_t      out_q;
  logic          out_valid_q;
  logic          advance;

  logic [AW-1:0] pc_q, pc_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] d_val, y, top;
  logic          fail, cnt_nz, cnt_ld, cnt_dec, full_next;
  msq_stk_ctrl_t stk_op, stk_ctrl;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign fail   = in_q.cond_fail;
  assign d_val  = AW'(in_q.branch_data);
  assign cnt_nz = (cnt_q != '0);

  always_comb begin
    y       = pc_q;
    stk_op  = '0;
    cnt_ld  = 1'b0;
    cnt_dec = 1'b0;
    case (op_e'(in_q.instruction))
      OP_JZ: begin
        y            = '0;
        stk_op.clear = 1'b1;
      end
      OP_CJS: begin
        if (!fail) begin
          y           = d_val;
          stk_op.push = 1'b1;
        end
      end
      OP_JMAP: y = d_val;
      OP_CJP, OP_CJV: y = fail ? pc_q : d_val;
      OP_PUSH: begin
        cnt_ld      = !fail;
        stk_op.push = 1'b1;
      end
      OP_JSRP: begin
        y           = fail ? cnt_q : d_val;
        stk_op.push = 1'b1;
      end
      OP_JRP: y = fail ? cnt_q : d_val;
      OP_RFCT: begin
        if (cnt_nz) begin
          y       = top;
          cnt_dec = 1'b1;
        end else begin
          stk_op.pop = 1'b1;
        end
      end
      OP_RPCT: begin
        if (cnt_nz) begin
          y       = d_val;
          cnt_dec = 1'b1;
        end
      end
      OP_CRTN: begin
        if (!fail) begin
          y          = top;
          stk_op.pop = 1'b1;
        end
      end
      OP_CJPP: begin
        if (!fail) begin
          y          = d_val;
          stk_op.pop = 1'b1;
        end
      end
      OP_LDCT: cnt_ld = 1'b1;
      OP_LOOP: begin
        if (fail) begin
          y = top;
        end else begin
          stk_op.pop = 1'b1;
        end
      end
      OP_CONT: y = pc_q;
      OP_TWB: begin
        if (cnt_nz) begin
          cnt_dec = 1'b1;
          if (fail) begin
            y = top;
          end else begin
            stk_op.pop = 1'b1;
          end
        end else begin
          stk_op.pop = 1'b1;
          y          = fail ? d_val : pc_q;
        end
      end
      default: y = pc_q;
    endcase
  end

  // external counter load overrides any decrement
  always_comb begin
    if (!in_q.load_counter_n || cnt_ld) begin
      cnt_d = d_val;
    end else if (cnt_dec) begin
      cnt_d = cnt_q - AddrOne;
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign pc_d = y + AddrOne;

  assign stk_ctrl.clear = stk_op.clear && advance;
  assign stk_ctrl.push  = stk_op.push && advance;
  assign stk_ctrl.pop   = stk_op.pop && advance;

  msq_stack #(
    .AW    (AW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (stk_ctrl),
    .push_data_i (pc_q),
    .top_o       (top),
    .full_next_o (full_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      cnt_q       <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
        cnt_q       <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.next_address <= DATA_W'(y);
      out_q.stack_full_n <= !full_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MSQ_ASSERT_NOW(a_no_bubble, in_valid_q && !out_valid_q, advance)
  `MSQ_ASSERT_NEXT(a_result_loaded, advance, out_valid_q)
  `MSQ_ASSERT_NEXT(a_jz_empties, advance && (in_q.instruction == OP_JZ), out_q.stack_full_n)

endmodule
`default_nettype wire
